@@ sv/lld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lld_pkg;

  // One input item: a new request or the completion of an earlier one.
  typedef struct packed {
    logic       action;
    logic [3:0] done_target;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_target;
    logic [15:0] pending_now;
  } out_item_t;

  localparam logic ACTION_REQUEST  = 1'b0;
  localparam logic ACTION_COMPLETE = 1'b1;

  localparam logic [1:0] STATUS_DISPATCHED = 2'd0;
  localparam logic [1:0] STATUS_REJECTED   = 2'd1;
  localparam logic [1:0] STATUS_COMPLETED  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PENDING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_CPL,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

@@ sv/least_loaded_dispatcher.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    lld_pkg::in_item_t
// out_      output     out_valid / out_ready  lld_pkg::out_item_t
// cfg_      input      cfg_we (no wait)       cfg_idx, cfg_wdata
//
// A dispatched request reads every entry within the effective target count: the load
// table has a single read port and is scanned one entry per cycle, then one state writes
// the chosen entry and one hands off the result. A completion reads, decrements and
// hands off; a rejected request goes straight to the response state.
// Reset is synchronous and active low; per-entry valid bits make the whole load table
// read as zero right after reset, so no clearing pass is needed.
// A stalled output holds only the result register; the next item is taken meanwhile and
// waits in the response state only if its own result finds the register still full.

module least_loaded_dispatcher #(
  parameter int unsigned NUM_TARGETS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lld_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lld_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [lld_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [lld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned TGT_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int unsigned NW    = TGT_W + 1;
  localparam int unsigned PW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic cnt_t sat_dec(input cnt_t v);
    return (v == '0) ? v : v - cnt_t'(1);
  endfunction

  // Configuration registers.
  logic [4:0]  tc_r;
  logic [15:0] max_pend_r;
  logic        lim_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r       <= 5'd1;
      max_pend_r <= 16'd1;
      lim_en_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lld_pkg::REG_TARGET_COUNT:  tc_r       <= cfg_wdata[4:0];
        lld_pkg::REG_MAX_PENDING:   max_pend_r <= cfg_wdata;
        lld_pkg::REG_LIMIT_ENABLED: lim_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Load table: one write port, one registered read port.
  cnt_t                   mem [NUM_TARGETS];
  logic [NUM_TARGETS-1:0] vld_r;
  cnt_t                   rd_data_r;
  logic                   rd_vld_r;
  logic                   mem_re;
  logic [TGT_W-1:0]       mem_raddr;
  logic                   mem_we;
  logic [TGT_W-1:0]       mem_waddr;
  cnt_t                   mem_wdata;
  cnt_t                   load_cur;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_r <= vld_r[mem_raddr];
      end
    end
  end

  // An entry never written since reset holds a load of zero.
  assign load_cur = rd_vld_r ? rd_data_r : '0;

  // Control and datapath registers.
  lld_pkg::state_t    state_r, state_nxt;
  cnt_t               pend_r, pend_nxt;
  logic [TGT_W-1:0]   ptr_r, ptr_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      left_r, left_nxt;
  logic [TGT_W-1:0]   idx_r, idx_nxt;
  logic [TGT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               first_r, first_nxt;
  logic [TGT_W-1:0]   best_r, best_nxt;
  cnt_t               best_load_r, best_load_nxt;
  logic [3:0]         done_r, done_nxt;
  logic               done_ok_r, done_ok_nxt;
  lld_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  lld_pkg::out_item_t out_data_r, out_data_nxt;

  logic          accept;
  logic          out_free;
  logic [15:0]   limit;
  logic          reject;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] ptr_ext;
  logic [NW-1:0] start;
  logic [NW-1:0] start_inc;
  logic [NW-1:0] idx_inc;
  logic          in_done_ok;
  cnt_t          pend_dec;
  cnt_t          pend_inc;

  assign in_ready  = (state_r == lld_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit  = (max_pend_r == 16'd0) ? 16'd1 : max_pend_r;
  assign reject = lim_en_r && (PW'(pend_r) >= PW'(limit));

  always_comb begin
    if (tc_r == 5'd0) begin
      n_eff = NW'(1);
    end else if (32'(tc_r) > 32'(NUM_TARGETS)) begin
      n_eff = NW'(NUM_TARGETS);
    end else begin
      n_eff = NW'(tc_r);
    end
  end

  // After the target count was lowered the pointer may sit outside it; the scan then
  // starts at target zero.
  assign ptr_ext   = NW'(ptr_r);
  assign start     = (ptr_ext < n_eff) ? ptr_ext : '0;
  assign start_inc = start + NW'(1);
  assign idx_inc   = NW'(idx_r) + NW'(1);

  assign in_done_ok = (32'(in_data.done_target) < 32'(NUM_TARGETS));
  assign pend_dec   = sat_dec(pend_r);
  assign pend_inc   = sat_inc(pend_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lld_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.action == lld_pkg::ACTION_COMPLETE) begin
            state_nxt = lld_pkg::ST_CPL;
          end else if (reject) begin
            state_nxt = lld_pkg::ST_RESP;
          end else begin
            state_nxt = lld_pkg::ST_SCAN;
          end
        end
      end
      lld_pkg::ST_SCAN: begin
        if (left_r == '0) begin
          state_nxt = lld_pkg::ST_UPD;
        end
      end
      lld_pkg::ST_UPD: state_nxt = lld_pkg::ST_RESP;
      lld_pkg::ST_CPL: state_nxt = lld_pkg::ST_RESP;
      lld_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = lld_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lld_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = best_r;
    mem_wdata     = sat_inc(best_load_r);
    pend_nxt      = pend_r;
    ptr_nxt       = ptr_r;
    n_nxt         = n_r;
    left_nxt      = left_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    first_nxt     = first_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    done_nxt      = done_r;
    done_ok_nxt   = done_ok_r;
    res_nxt       = res_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      lld_pkg::ST_IDLE: begin
        if (accept) begin
          done_nxt    = in_data.done_target;
          done_ok_nxt = in_done_ok;
          if (in_data.action == lld_pkg::ACTION_COMPLETE) begin
            mem_re     = in_done_ok;
            mem_raddr  = TGT_W'(in_data.done_target);
            rd_idx_nxt = TGT_W'(in_data.done_target);
          end else if (reject) begin
            res_nxt.status        = lld_pkg::STATUS_REJECTED;
            res_nxt.chosen_target = 4'd0;
            res_nxt.pending_now   = 16'(pend_r);
          end else begin
            // The first read goes out now; the rest follow one per cycle.
            mem_re     = 1'b1;
            mem_raddr  = TGT_W'(start);
            rd_idx_nxt = TGT_W'(start);
            idx_nxt    = TGT_W'(start);
            n_nxt      = n_eff;
            left_nxt   = n_eff - NW'(1);
            first_nxt  = 1'b1;
            ptr_nxt    = (start_inc >= n_eff) ? '0 : TGT_W'(start_inc);
          end
        end
      end
      lld_pkg::ST_SCAN: begin
        // Only a strictly smaller load displaces the earlier pick in rotation order.
        if (first_r || (load_cur < best_load_r)) begin
          best_nxt      = rd_idx_r;
          best_load_nxt = load_cur;
        end
        first_nxt = 1'b0;
        if (left_r != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = (idx_inc >= n_r) ? '0 : TGT_W'(idx_inc);
          idx_nxt    = mem_raddr;
          rd_idx_nxt = mem_raddr;
          left_nxt   = left_r - NW'(1);
        end
      end
      lld_pkg::ST_UPD: begin
        mem_we                = 1'b1;
        mem_waddr             = best_r;
        mem_wdata             = sat_inc(best_load_r);
        pend_nxt              = pend_inc;
        res_nxt.status        = lld_pkg::STATUS_DISPATCHED;
        res_nxt.chosen_target = 4'(best_r);
        res_nxt.pending_now   = 16'(pend_inc);
      end
      lld_pkg::ST_CPL: begin
        mem_we                = done_ok_r;
        mem_waddr             = rd_idx_r;
        mem_wdata             = sat_dec(load_cur);
        pend_nxt              = pend_dec;
        res_nxt.status        = lld_pkg::STATUS_COMPLETED;
        res_nxt.chosen_target = done_r;
        res_nxt.pending_now   = 16'(pend_dec);
      end
      lld_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lld_pkg::ST_IDLE;
      pend_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    done_r      <= done_nxt;
    done_ok_r   <= done_ok_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire
